// File: rtl/core/som_pkg.sv
// shared types and constants of the shift-or string matcher
`timescale 1ns / 1ps

package som_pkg;

  // fixed field widths
  localparam int CMD_BITS   = 2;
  localparam int SYM_BITS   = 7;
  localparam int TOTAL_BITS = 32;

  // command codes as they arrive on the cmd field
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_START  = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_TEXT   = 2'd3;

  // decoded operation carried from front to back
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_START  = 2'd2,
    OP_TEXT   = 2'd3
  } som_op_e_t;

  // one queued item
  typedef struct packed {
    som_op_e_t             op;
    logic [SYM_BITS-1:0]   symbol;
    logic                  in_alpha;
  } som_op_t;

  // queue status seen by the top level
  typedef struct packed {
    logic [1:0] level;
  } som_front_status_t;

endpackage

// File: rtl/core/som_front.sv
// front end: accepts items, decodes commands and queues them
`timescale 1ns / 1ps

module som_front #(
  parameter int ALPHABET_SIZE = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [som_pkg::CMD_BITS-1:0]      cmd,
  input  logic [som_pkg::SYM_BITS-1:0]      symbol,
  output logic                              q_valid,
  input  logic                              q_ready,
  output som_pkg::som_op_t                  q_data,
  output som_pkg::som_front_status_t        status
);

  localparam logic [1:0] DEPTH = 2'd2;

  som_pkg::som_op_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       level;
  som_pkg::som_op_t decoded;
  logic             push;
  logic             pop;

  // decode the command and flag symbols outside the alphabet
  always_comb begin
    case (cmd)
      som_pkg::CMD_CLEAR:  decoded.op = som_pkg::OP_CLEAR;
      som_pkg::CMD_APPEND: decoded.op = som_pkg::OP_APPEND;
      som_pkg::CMD_START:  decoded.op = som_pkg::OP_START;
      default:             decoded.op = som_pkg::OP_TEXT;
    endcase
    decoded.symbol   = symbol;
    decoded.in_alpha = (32'(symbol) < ALPHABET_SIZE);
  end

  assign in_ready = (level != DEPTH);
  assign push     = in_valid && in_ready;
  assign q_valid  = (level != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = entries[rd_ptr];
  assign status.level = level;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

// File: rtl/core/som_back.sv
// back end: column table, search state and the result register
`timescale 1ns / 1ps

module som_back #(
  parameter int ALPHABET_SIZE = 128,
  parameter int WORD_BITS     = 64,
  parameter int COUNT_BITS    = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  output logic                               q_ready,
  input  som_pkg::som_op_t                   q_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               match_found,
  output logic [som_pkg::TOTAL_BITS-1:0]     match_total,
  output logic                               pattern_overflow
);

  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int LW = $clog2(WORD_BITS + 1);
  localparam logic [WORD_BITS-1:0]  WORD_ONES  = {WORD_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [LW-1:0]         LEN_FULL   = LW'(WORD_BITS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // column table and its valid bits
  logic [WORD_BITS-1:0]     col_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] col_vld;
  logic [WORD_BITS-1:0]     col_rd;
  logic                     col_rd_vld;

  // item being carried out
  som_pkg::som_op_t         cur;

  // search state
  logic [WORD_BITS-1:0]     search_vector;
  logic [WORD_BITS-1:0]     match_limit;
  logic [LW-1:0]            pattern_length;
  logic [COUNT_BITS-1:0]    hit_count;

  logic                     pop;
  logic                     fire;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic [WORD_BITS-1:0]     col;
  logic [WORD_BITS-1:0]     vec_next;
  logic                     found;
  logic                     full;
  logic                     mem_we;
  logic [WORD_BITS-1:0]     wdata;

  assign q_ready = (state == S_IDLE);
  assign pop     = q_valid && q_ready;
  assign fire    = (state == S_EXEC) && (!out_valid || out_ready);
  assign raddr   = AW'(q_data.symbol);
  assign waddr   = AW'(cur.symbol);

  // column of the current symbol, all ones when never written or out of range
  assign col      = (cur.in_alpha && col_rd_vld) ? col_rd : WORD_ONES;
  assign vec_next = (search_vector << 1) | col;
  assign found    = (vec_next < match_limit);
  assign full     = (pattern_length >= LEN_FULL);
  assign mem_we   = fire && (cur.op == som_pkg::OP_APPEND) && !full && cur.in_alpha;
  assign wdata    = col & ~(WORD_BITS'(1) << pattern_length);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (pop) state_next = S_EXEC;
      S_EXEC:  if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // table memory: read at pop, write on append
  always_ff @(posedge clk) begin
    if (pop) begin
      col_rd <= col_mem[raddr];
      cur    <= q_data;
    end
    if (mem_we) begin
      col_mem[waddr] <= wdata;
    end
  end

  // valid bits of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      col_vld    <= '0;
      col_rd_vld <= 1'b0;
    end else begin
      if (pop) begin
        col_rd_vld <= q_data.in_alpha && col_vld[raddr];
      end
      if (fire && (cur.op == som_pkg::OP_CLEAR)) begin
        col_vld <= '0;
      end else if (mem_we) begin
        col_vld[waddr] <= 1'b1;
      end
    end
  end

  // pattern and search state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      search_vector  <= WORD_ONES;
      match_limit    <= WORD_ONES;
      pattern_length <= '0;
      hit_count      <= '0;
    end else if (fire) begin
      case (cur.op)
        som_pkg::OP_CLEAR: begin
          pattern_length <= '0;
          match_limit    <= WORD_ONES;
        end
        som_pkg::OP_APPEND: begin
          if (!full) begin
            pattern_length <= pattern_length + LW'(1);
            if (pattern_length != '0) begin
              match_limit <= match_limit << 1;
            end
          end
        end
        som_pkg::OP_START: begin
          search_vector <= WORD_ONES;
          hit_count     <= '0;
        end
        default: begin
          search_vector <= vec_next;
          if (found && (hit_count != COUNT_MAX)) begin
            hit_count <= hit_count + COUNT_BITS'(1);
          end
        end
      endcase
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      match_found      <= (cur.op == som_pkg::OP_TEXT) && found;
      pattern_overflow <= (cur.op == som_pkg::OP_APPEND) && full;
      case (cur.op)
        som_pkg::OP_START: begin
          match_total <= '0;
        end
        som_pkg::OP_TEXT: begin
          if (found && (hit_count != COUNT_MAX)) begin
            match_total <= som_pkg::TOTAL_BITS'(hit_count + COUNT_BITS'(1));
          end else begin
            match_total <= som_pkg::TOTAL_BITS'(hit_count);
          end
        end
        default: begin
          match_total <= som_pkg::TOTAL_BITS'(hit_count);
        end
      endcase
    end
  end

endmodule

// File: rtl/core/shift_or_string_matcher_top.sv
// Shift-or exact string matcher: load a pattern of up to WORD_BITS symbols
// with clear and append commands, then stream text symbols; each item gives
// one result with the match flag, the saturating match count of the current
// text and the pattern overflow flag. Every item passes through the states
// S_IDLE and S_EXEC of the execution unit: S_IDLE reads the symbol's column
// from the single-port column table, S_EXEC updates the table or search
// vector and loads the result register; only then is the next item read.
// A two-entry queue sits between the command decoder and the execution unit,
// and new items are taken while a result waits in the output register.
// The column table needs no clearing pass: per-symbol valid bits are
// all dropped at once by reset or a clear command.
`timescale 1ns / 1ps

module shift_or_string_matcher_top #(
  parameter int ALPHABET_SIZE = 128,
  parameter int WORD_BITS     = 64,
  parameter int COUNT_BITS    = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [som_pkg::CMD_BITS-1:0]      cmd,
  input  logic [som_pkg::SYM_BITS-1:0]      symbol,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              match_found,
  output logic [som_pkg::TOTAL_BITS-1:0]    match_total,
  output logic                              pattern_overflow
);

  logic                       q_valid;
  logic                       q_ready;
  som_pkg::som_op_t           q_data;
  som_pkg::som_front_status_t front_status;

  // decode and queue
  som_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .symbol   (symbol),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .status   (front_status)
  );

  // execute
  som_back #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .WORD_BITS     (WORD_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_data           (q_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .match_found      (match_found),
    .match_total      (match_total),
    .pattern_overflow (pattern_overflow)
  );

  // queue never holds more than two items
  assert property (@(posedge clk) disable iff (rst) front_status.level <= 2'd2)
    else $error("queue level beyond depth");

  // a result never reports both a match and a refused pattern symbol
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(match_found && pattern_overflow))
    else $error("match and overflow in one result");

  // an empty queue always takes an item
  assert property (@(posedge clk) disable iff (rst)
    (front_status.level == 2'd0) |-> in_ready)
    else $error("empty queue refuses items");

  // the execution unit only pops an item the queue holds
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |-> (front_status.level != 2'd0))
    else $error("pop from empty queue");

endmodule
